### rtl/core/pwmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmp_pkg
// Shared types and constants of the peer wire message parser: message ids,
// status codes, parse phases and the result record.
// ----------------------------------------------------------------------------
package pwmp_pkg;

  // Bytes of bitfield the peer may announce
  localparam int unsigned BF_CAP = 512;
  localparam int unsigned BF_CNT_W = $clog2(BF_CAP + 1);

  // Frame layout
  localparam int unsigned LEN_BYTES = 4;
  localparam int unsigned HAVE_BYTES = 4;
  localparam int unsigned PIECE_IDX_BYTES = 4;
  localparam int unsigned PIECE_HDR_BYTES = 8;

  // Message ids
  localparam logic [3:0] KIND_CHOKE          = 4'd0;
  localparam logic [3:0] KIND_UNCHOKE        = 4'd1;
  localparam logic [3:0] KIND_INTERESTED     = 4'd2;
  localparam logic [3:0] KIND_NOT_INTERESTED = 4'd3;
  localparam logic [3:0] KIND_HAVE           = 4'd4;
  localparam logic [3:0] KIND_BITFIELD       = 4'd5;
  localparam logic [3:0] KIND_REQUEST        = 4'd6;
  localparam logic [3:0] KIND_PIECE          = 4'd7;
  localparam logic [3:0] KIND_CANCEL         = 4'd8;
  localparam logic [3:0] KIND_PORT           = 4'd9;
  localparam logic [3:0] KIND_KEEPALIVE      = 4'd10;
  localparam logic [7:0] ID_MAX              = 8'd9;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNKNOWN_ID  = 3'd1,
    ST_HAVE_SIZE   = 3'd2,
    ST_PIECE_SHORT = 3'd3,
    ST_HAVE_RANGE  = 3'd4,
    ST_BF_TRUNC    = 3'd5
  } pwmp_status_t;

  // Parse phases
  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_ID   = 2'd1,
    PH_PAY  = 2'd2,
    PH_DEAD = 2'd3
  } pwmp_phase_t;

  // One stream byte handed to the parser
  typedef struct packed {
    logic       take;
    logic [7:0] data;
  } pwmp_byte_t;

  // One result record
  typedef struct packed {
    logic [3:0]   kind;
    logic         message_end;
    logic         data_valid;
    logic [7:0]   data_byte;
    logic [31:0]  data_offset;
    logic [31:0]  payload_length;
    logic [31:0]  piece_index;
    logic [31:0]  piece_begin;
    logic [31:0]  have_index;
    pwmp_status_t status;
    logic         peer_choking;
    logic         peer_interested;
  } pwmp_result_t;

endpackage

### rtl/core/pwmp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmp_in_reg
// Input register of the stream channel. Holds one byte until the parser can
// take it and raises stall while a held byte has nowhere to go.
// ----------------------------------------------------------------------------
module pwmp_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                stream_valid,
  input  logic [7:0]          stream_byte,
  output logic                stream_stall,
  input  logic                out_ready,
  output pwmp_pkg::pwmp_byte_t in_byte
);
  import pwmp_pkg::*;

  logic       held;
  logic [7:0] held_byte;
  logic       take;

  // Take the held byte whenever the result slot is free
  assign take         = held && out_ready;
  assign stream_stall = held && !out_ready;

  // Load a new request, drop the held byte once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!stream_stall) begin
      held <= stream_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stream_stall && stream_valid) begin
      held_byte <= stream_byte;
    end
  end

  assign in_byte.take = take;
  assign in_byte.data = held_byte;

endmodule

### rtl/core/pwmp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmp_parser
// Frame state and per-byte decode. Assembles the length, checks the id,
// gathers HAVE and PIECE header fields, and forms the result for the byte.
// ----------------------------------------------------------------------------
module pwmp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  pwmp_pkg::pwmp_byte_t  in_byte,
  output logic                  emit,
  output pwmp_pkg::pwmp_result_t res
);
  import pwmp_pkg::*;

  pwmp_phase_t         phase, phase_next;
  logic [31:0]         byte_count, byte_count_next;
  logic [31:0]         frame_length, frame_length_next;
  logic [31:0]         plen, plen_next;
  logic [31:0]         payload_last, payload_last_next;
  logic [3:0]          message_kind, message_kind_next;
  logic [31:0]         field_shift, field_shift_next;
  logic [31:0]         held_piece_index, held_piece_index_next;
  logic [31:0]         held_piece_begin, held_piece_begin_next;
  logic                choking_flag, choking_flag_next;
  logic                interested_flag, interested_flag_next;
  logic [BF_CNT_W-1:0] bitfield_bytes, bitfield_bytes_next;
  logic                truncated_flag, truncated_flag_next;

  logic [7:0]          b;
  logic [31:0]         fl;
  logic                last;
  logic                finish;

  assign b    = in_byte.data;
  assign fl   = {frame_length[23:0], b};
  assign last = (byte_count == payload_last);

  // Decode one byte and form its result
  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    frame_length_next     = frame_length;
    plen_next             = plen;
    payload_last_next     = payload_last;
    message_kind_next     = message_kind;
    field_shift_next      = field_shift;
    held_piece_index_next = held_piece_index;
    held_piece_begin_next = held_piece_begin;
    choking_flag_next     = choking_flag;
    interested_flag_next  = interested_flag;
    bitfield_bytes_next   = bitfield_bytes;
    truncated_flag_next   = truncated_flag;
    finish                = 1'b0;
    emit                  = 1'b0;
    res                   = '0;
    res.status            = ST_OK;

    unique case (phase)
      PH_LEN: begin
        frame_length_next = fl;
        byte_count_next   = byte_count + 32'd1;
        if (byte_count[1:0] == 2'(LEN_BYTES - 1)) begin
          byte_count_next   = '0;
          plen_next         = fl - 32'd1;
          payload_last_next = fl - 32'd2;
          if (fl == '0) begin
            emit             = 1'b1;
            res.kind         = KIND_KEEPALIVE;
            res.message_end  = 1'b1;
          end else begin
            phase_next = PH_ID;
          end
        end
      end

      PH_ID: begin
        if (b > ID_MAX) begin
          phase_next         = PH_DEAD;
          emit               = 1'b1;
          res.kind           = KIND_CHOKE;
          res.message_end    = 1'b1;
          res.payload_length = plen;
          res.status         = ST_UNKNOWN_ID;
        end else begin
          message_kind_next     = b[3:0];
          field_shift_next      = '0;
          held_piece_index_next = '0;
          held_piece_begin_next = '0;
          truncated_flag_next   = 1'b0;
          byte_count_next       = '0;
          if (plen == '0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_PAY;
          end
        end
      end

      PH_PAY: begin
        byte_count_next = byte_count + 32'd1;
        if (message_kind == KIND_HAVE) begin
          if (plen == 32'(HAVE_BYTES)) begin
            field_shift_next = {field_shift[23:0], b};
          end
          finish = last;
        end else if (message_kind == KIND_BITFIELD) begin
          if (byte_count >= 32'(BF_CAP)) begin
            truncated_flag_next = 1'b1;
          end
          finish = last;
        end else if (message_kind == KIND_PIECE && plen >= 32'(PIECE_HDR_BYTES)) begin
          if (byte_count < 32'(PIECE_IDX_BYTES)) begin
            held_piece_index_next = {held_piece_index[23:0], b};
            finish = last;
          end else if (byte_count < 32'(PIECE_HDR_BYTES)) begin
            held_piece_begin_next = {held_piece_begin[23:0], b};
            finish = last;
          end else begin
            // Pass one block data byte
            emit               = 1'b1;
            res.kind           = KIND_PIECE;
            res.message_end    = last;
            res.data_valid     = 1'b1;
            res.data_byte      = b;
            res.data_offset    = byte_count - 32'(PIECE_HDR_BYTES);
            res.payload_length = plen;
            res.piece_index    = held_piece_index;
            res.piece_begin    = held_piece_begin;
            if (last) begin
              phase_next      = PH_LEN;
              byte_count_next = '0;
            end
          end
        end else begin
          finish = last;
        end
      end

      PH_DEAD: begin
      end

      default: begin
      end
    endcase

    // Close the message: act on its kind and report
    if (finish) begin
      phase_next         = PH_LEN;
      byte_count_next    = '0;
      emit               = 1'b1;
      res.kind           = message_kind_next;
      res.message_end    = 1'b1;
      res.payload_length = plen;
      case (message_kind_next)
        KIND_CHOKE:          choking_flag_next = 1'b1;
        KIND_UNCHOKE:        choking_flag_next = 1'b0;
        KIND_INTERESTED:     interested_flag_next = 1'b1;
        KIND_NOT_INTERESTED: interested_flag_next = 1'b0;
        KIND_HAVE: begin
          if (plen != 32'(HAVE_BYTES)) begin
            res.status = ST_HAVE_SIZE;
          end else begin
            res.have_index = field_shift_next;
            if (field_shift_next >= (32'(bitfield_bytes) << 3)) begin
              res.status = ST_HAVE_RANGE;
            end
          end
        end
        KIND_BITFIELD: begin
          if (plen != '0) begin
            bitfield_bytes_next = (plen > 32'(BF_CAP)) ? BF_CNT_W'(BF_CAP)
                                                       : plen[BF_CNT_W-1:0];
            if (truncated_flag_next) begin
              res.status = ST_BF_TRUNC;
            end
          end
        end
        KIND_PIECE: begin
          if (plen < 32'(PIECE_HDR_BYTES)) begin
            res.status = ST_PIECE_SHORT;
          end else begin
            res.piece_index = held_piece_index_next;
            res.piece_begin = held_piece_begin_next;
          end
        end
        default: begin
        end
      endcase
    end

    res.peer_choking    = choking_flag_next;
    res.peer_interested = interested_flag_next;

    // Hold everything unless a byte is taken
    if (!in_byte.take) begin
      emit                  = 1'b0;
      phase_next            = phase;
      byte_count_next       = byte_count;
      frame_length_next     = frame_length;
      plen_next             = plen;
      payload_last_next     = payload_last;
      message_kind_next     = message_kind;
      field_shift_next      = field_shift;
      held_piece_index_next = held_piece_index;
      held_piece_begin_next = held_piece_begin;
      choking_flag_next     = choking_flag;
      interested_flag_next  = interested_flag;
      bitfield_bytes_next   = bitfield_bytes;
      truncated_flag_next   = truncated_flag;
    end
  end

  // Advance the frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LEN;
      byte_count       <= '0;
      frame_length     <= '0;
      plen             <= '0;
      payload_last     <= '0;
      message_kind     <= '0;
      field_shift      <= '0;
      held_piece_index <= '0;
      held_piece_begin <= '0;
      choking_flag     <= 1'b1;
      interested_flag  <= 1'b0;
      bitfield_bytes   <= '0;
      truncated_flag   <= 1'b0;
    end else begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      frame_length     <= frame_length_next;
      plen             <= plen_next;
      payload_last     <= payload_last_next;
      message_kind     <= message_kind_next;
      field_shift      <= field_shift_next;
      held_piece_index <= held_piece_index_next;
      held_piece_begin <= held_piece_begin_next;
      choking_flag     <= choking_flag_next;
      interested_flag  <= interested_flag_next;
      bitfield_bytes   <= bitfield_bytes_next;
      truncated_flag   <= truncated_flag_next;
    end
  end

endmodule

### rtl/core/pwmp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmp_out_reg
// Result register of the output channel. Holds a result until the receiver
// takes it and tells the input side when the slot is free.
// ----------------------------------------------------------------------------
module pwmp_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  pwmp_pkg::pwmp_result_t res_in,
  input  logic                  result_stall,
  output logic                  result_valid,
  output pwmp_pkg::pwmp_result_t res_out,
  output logic                  out_ready
);
  import pwmp_pkg::*;

  assign out_ready = !result_valid || !result_stall;

  // Load a new result, drop the old one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

### rtl/core/peer_wire_message_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_wire_message_parser_core
// Parses a peer wire byte stream into message results.
//
// The stream channel (stream_valid, stream_stall, stream_byte) takes one byte
// of the connection per request. Frames are a 4-byte big-endian length, an id
// byte and the payload. The result channel (result_valid, result_stall and the
// result fields) gives at most one result per byte: keep-alives, closed
// messages with their status, and one result per PIECE block data byte.
// A byte passes an input register and the decode logic into the result
// register: its result is loaded there when the held byte is taken, and
// one byte is accepted every cycle while the receiver keeps up.
// Reset leaves the parser waiting for a length, the peer marked choking and
// not interested, and no bitfield known. An id above 9 is reported once and
// every later byte is dropped until reset.
// While the receiver stalls, the result stays put; one more byte is taken
// into the input register, then stream_stall rises until the result leaves.
// ----------------------------------------------------------------------------
module peer_wire_message_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  kind,
  output logic        message_end,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic [31:0] data_offset,
  output logic [31:0] payload_length,
  output logic [31:0] piece_index,
  output logic [31:0] piece_begin,
  output logic [31:0] have_index,
  output logic [2:0]  status,
  output logic        peer_choking,
  output logic        peer_interested
);
  import pwmp_pkg::*;

  pwmp_byte_t   in_byte;
  pwmp_result_t res_next;
  pwmp_result_t res;
  logic         emit;
  logic         out_ready;

  pwmp_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_byte  (stream_byte),
    .stream_stall (stream_stall),
    .out_ready    (out_ready),
    .in_byte      (in_byte)
  );

  pwmp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_byte),
    .emit    (emit),
    .res     (res_next)
  );

  pwmp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .res_in       (res_next),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .res_out      (res),
    .out_ready    (out_ready)
  );

  // Drive the result fields
  assign kind            = res.kind;
  assign message_end     = res.message_end;
  assign data_valid      = res.data_valid;
  assign data_byte       = res.data_byte;
  assign data_offset     = res.data_offset;
  assign payload_length  = res.payload_length;
  assign piece_index     = res.piece_index;
  assign piece_begin     = res.piece_begin;
  assign have_index      = res.have_index;
  assign status          = res.status;
  assign peer_choking    = res.peer_choking;
  assign peer_interested = res.peer_interested;

  // Only PIECE results carry data bytes
  a_data_is_piece: assert property (@(posedge clk) disable iff (rst)
    result_valid && data_valid |-> kind == KIND_PIECE)
    else $error("data byte on a non-PIECE result");

  // A result that does not close its message is a data byte
  a_open_is_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !message_end |-> data_valid)
    else $error("open result without a data byte");

  // Fatal id reports close the message with kind zero
  a_fatal_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_UNKNOWN_ID |-> message_end && !data_valid &&
      kind == KIND_CHOKE)
    else $error("malformed fatal id report");

  // Input stalls only under output back-pressure
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    stream_stall |-> result_valid && result_stall)
    else $error("input stalled without output back-pressure");

endmodule
